FILE: sv/lpcp_pkg.sv
// shared types and constants of the label printer command parser
package lpcp_pkg;

    // parser position
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ESC,
        ST_ESCI,
        ST_MODE,
        ST_COMP,
        ST_LENLO,
        ST_LENHI,
        ST_ROW,
        ST_SKIP
    } parse_state_t;

    // status codes of a record
    localparam logic [1:0] SC_REPLY = 2'd0;
    localparam logic [1:0] SC_DONE  = 2'd1;
    localparam logic [1:0] SC_ERROR = 2'd2;
    localparam logic [1:0] SC_PHASE = 2'd3;

    // phase values
    localparam logic PH_EDIT  = 1'b0;
    localparam logic PH_PRINT = 1'b1;

    // input opcodes
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // command stream bytes
    localparam logic [7:0] CH_ESC  = 8'h1b;
    localparam logic [7:0] CH_AT   = 8'h40;
    localparam logic [7:0] CH_I    = 8'h69;
    localparam logic [7:0] CH_M    = 8'h4d;
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_Z    = 8'h5a;
    localparam logic [7:0] CH_FF   = 8'h0c;
    localparam logic [7:0] CH_SUB  = 8'h1a;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_LZ   = 8'h7a;
    localparam logic [7:0] CH_K    = 8'h4b;
    localparam logic [7:0] CH_D    = 8'h64;

    // argument counts of the ESC i commands
    localparam logic [15:0] ARGS_Z  = 16'd10;
    localparam logic [15:0] ARGS_MK = 16'd1;
    localparam logic [15:0] ARGS_D  = 16'd2;

    // configuration register indexes
    localparam logic [2:0] REG_ERR_ONE  = 3'd0;
    localparam logic [2:0] REG_ERR_TWO  = 3'd1;
    localparam logic [2:0] REG_WIDTH    = 3'd2;
    localparam logic [2:0] REG_MEDIA    = 3'd3;
    localparam logic [2:0] REG_TAPE     = 3'd4;
    localparam logic [2:0] REG_INK      = 3'd5;
    localparam logic [2:0] REG_MODEL    = 3'd6;

    // configuration reset values
    localparam logic [7:0] RST_WIDTH = 8'd24;
    localparam logic [7:0] RST_MEDIA = 8'd1;
    localparam logic [7:0] RST_TAPE  = 8'd1;
    localparam logic [7:0] RST_INK   = 8'd8;
    localparam logic [7:0] RST_MODEL = 8'd103;

endpackage

FILE: sv/label_printer_command_parser.sv
// label printer command parser: byte parser, event queue and record output
// path: an accepted item is held in the input register until the event queue has room; the
// parser acts on it and writes any event to the queue, which loads the record output register
// throughput: one item per cycle while the queue is not full; a page end yields three records,
// one per cycle while out_stall is low, so a page end stream is limited by the record output
// reset: rst_n (async, active low) clears parser, counters and queue, config to its defaults
module label_printer_command_parser #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // input item channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  data_byte,
    // result item channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status_code,
    output logic        phase,
    output logic [7:0]  err_one,
    output logic [7:0]  err_two,
    output logic [7:0]  tape_width,
    output logic [7:0]  media_code,
    output logic [7:0]  tape_id,
    output logic [7:0]  text_id,
    output logic [7:0]  model_id,
    output logic [31:0] rows_count,
    output logic [31:0] pages_count,
    output logic        last,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // event queue between the parser and the record output
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [7:0] err_one_reg, err_two_reg, width_reg, media_reg;
    logic [7:0] tape_reg, ink_reg, model_reg;
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_one_reg <= '0;
            err_two_reg <= '0;
            width_reg   <= lpcp_pkg::RST_WIDTH;
            media_reg   <= lpcp_pkg::RST_MEDIA;
            tape_reg    <= lpcp_pkg::RST_TAPE;
            ink_reg     <= lpcp_pkg::RST_INK;
            model_reg   <= lpcp_pkg::RST_MODEL;
        end
        else if (cfg_wr)
        begin
            // writes past the last register are dropped
            case (cfg_idx)
                lpcp_pkg::REG_ERR_ONE: err_one_reg <= pwdata[7:0];
                lpcp_pkg::REG_ERR_TWO: err_two_reg <= pwdata[7:0];
                lpcp_pkg::REG_WIDTH:   width_reg   <= pwdata[7:0];
                lpcp_pkg::REG_MEDIA:   media_reg   <= pwdata[7:0];
                lpcp_pkg::REG_TAPE:    tape_reg    <= pwdata[7:0];
                lpcp_pkg::REG_INK:     ink_reg     <= pwdata[7:0];
                lpcp_pkg::REG_MODEL:   model_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        case (cfg_idx)
            lpcp_pkg::REG_ERR_ONE: prdata[7:0] = err_one_reg;
            lpcp_pkg::REG_ERR_TWO: prdata[7:0] = err_two_reg;
            lpcp_pkg::REG_WIDTH:   prdata[7:0] = width_reg;
            lpcp_pkg::REG_MEDIA:   prdata[7:0] = media_reg;
            lpcp_pkg::REG_TAPE:    prdata[7:0] = tape_reg;
            lpcp_pkg::REG_INK:     prdata[7:0] = ink_reg;
            lpcp_pkg::REG_MODEL:   prdata[7:0] = model_reg;
            default:               prdata      = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic       in_vld_reg;
    logic       opcode_reg;
    logic [7:0] byte_reg;
    logic       q_full;
    logic       adv;
    logic       in_take;

    // the held item moves into the parser unless the event queue is full
    assign adv      = in_vld_reg && !q_full;
    assign in_stall = in_vld_reg && q_full;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (adv)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            opcode_reg <= opcode;
            byte_reg   <= data_byte;
        end
    end

    // ------------------------------------------------------------------
    // parser: state register and next-state logic
    // ------------------------------------------------------------------
    lpcp_pkg::parse_state_t state_reg, state_next;
    logic [15:0]            skip_reg, skip_next;
    logic [7:0]             len_lo_reg, len_lo_next;
    logic [COUNT_WIDTH-1:0] rows_reg, rows_next;
    logic [COUNT_WIDTH-1:0] pages_reg, pages_next;
    logic                   push;       // an event goes to the queue
    logic                   push_page;  // event is a page end (else a status reply)
    logic                   start;      // byte is taken as a fresh opcode
    logic                   row_inc;
    logic                   page_inc;
    logic [15:0]            len_full;
    logic [15:0]            skip_dec;

    assign len_full = {byte_reg, len_lo_reg};
    assign skip_dec = skip_reg - 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lpcp_pkg::ST_IDLE;
            skip_reg   <= '0;
            len_lo_reg <= '0;
            rows_reg   <= '0;
            pages_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            skip_reg   <= skip_next;
            len_lo_reg <= len_lo_next;
            rows_reg   <= rows_next;
            pages_reg  <= pages_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        skip_next   = skip_reg;
        len_lo_next = len_lo_reg;
        rows_next   = rows_reg;
        pages_next  = pages_reg;
        push        = 1'b0;
        push_page   = 1'b0;
        start       = 1'b0;
        row_inc     = 1'b0;
        page_inc    = 1'b0;

        if (adv && opcode_reg == lpcp_pkg::OP_FLUSH)
        begin
            // flush: parser and counters back to reset, registers untouched
            state_next  = lpcp_pkg::ST_IDLE;
            skip_next   = '0;
            len_lo_next = '0;
            rows_next   = '0;
            pages_next  = '0;
        end
        else if (adv)
        begin
            case (state_reg)
                lpcp_pkg::ST_ESC:
                begin
                    if (byte_reg == lpcp_pkg::CH_AT)
                        state_next = lpcp_pkg::ST_IDLE;
                    else if (byte_reg == lpcp_pkg::CH_I)
                        state_next = lpcp_pkg::ST_ESCI;
                    else
                        start = 1'b1;   // ESC dropped, byte parsed again
                end
                lpcp_pkg::ST_ESCI:
                begin
                    state_next = lpcp_pkg::ST_IDLE;
                    case (byte_reg)
                        lpcp_pkg::CH_S:
                        begin
                            push = 1'b1;
                        end
                        lpcp_pkg::CH_A:
                        begin
                            state_next = lpcp_pkg::ST_MODE;
                        end
                        lpcp_pkg::CH_LZ:
                        begin
                            skip_next  = lpcp_pkg::ARGS_Z;
                            state_next = lpcp_pkg::ST_SKIP;
                        end
                        lpcp_pkg::CH_M, lpcp_pkg::CH_K:
                        begin
                            skip_next  = lpcp_pkg::ARGS_MK;
                            state_next = lpcp_pkg::ST_SKIP;
                        end
                        lpcp_pkg::CH_D:
                        begin
                            skip_next  = lpcp_pkg::ARGS_D;
                            state_next = lpcp_pkg::ST_SKIP;
                        end
                        default:
                        begin
                            start = 1'b1;   // ESC i dropped, byte parsed again
                        end
                    endcase
                end
                lpcp_pkg::ST_MODE, lpcp_pkg::ST_COMP:
                begin
                    // mode or compression byte consumed, nothing downstream depends on it
                    state_next = lpcp_pkg::ST_IDLE;
                end
                lpcp_pkg::ST_LENLO:
                begin
                    len_lo_next = byte_reg;
                    state_next  = lpcp_pkg::ST_LENHI;
                end
                lpcp_pkg::ST_LENHI:
                begin
                    if (len_full == 16'd0)
                    begin
                        row_inc    = 1'b1;
                        state_next = lpcp_pkg::ST_IDLE;
                    end
                    else
                    begin
                        skip_next  = len_full;
                        state_next = lpcp_pkg::ST_ROW;
                    end
                end
                lpcp_pkg::ST_ROW:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        row_inc    = 1'b1;
                        state_next = lpcp_pkg::ST_IDLE;
                    end
                end
                lpcp_pkg::ST_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                        state_next = lpcp_pkg::ST_IDLE;
                end
                default:
                begin
                    start = 1'b1;
                end
            endcase

            if (start)
            begin
                state_next = lpcp_pkg::ST_IDLE;
                case (byte_reg)
                    lpcp_pkg::CH_ESC: state_next = lpcp_pkg::ST_ESC;
                    lpcp_pkg::CH_M:   state_next = lpcp_pkg::ST_COMP;
                    lpcp_pkg::CH_G:   state_next = lpcp_pkg::ST_LENLO;
                    lpcp_pkg::CH_Z:   row_inc    = 1'b1;
                    lpcp_pkg::CH_FF, lpcp_pkg::CH_SUB:
                    begin
                        page_inc  = 1'b1;
                        push      = 1'b1;
                        push_page = 1'b1;
                    end
                    default: ;      // unknown opcode byte skipped
                endcase
            end

            if (row_inc)
                rows_next = rows_reg + COUNT_WIDTH'(1);
            if (page_inc)
                pages_next = pages_reg + COUNT_WIDTH'(1);
        end
    end

    // low 32 bits of the counters as the record shows them
    logic [COUNT_WIDTH+31:0] rows_ext, pages_ext;

    assign rows_ext  = {32'd0, rows_next};
    assign pages_ext = {32'd0, pages_next};

    // ------------------------------------------------------------------
    // event queue: one entry per status reply or page end
    // ------------------------------------------------------------------
    logic              q_page_reg  [QDEPTH];
    logic [31:0]       q_rows_reg  [QDEPTH];
    logic [31:0]       q_pages_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] q_cnt_reg;
    logic              q_empty;
    logic              pop;

    assign q_full  = (q_cnt_reg == QCNT_W'(QDEPTH));
    assign q_empty = (q_cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_page_reg[wr_ptr_reg]  <= push_page;
            q_rows_reg[wr_ptr_reg]  <= rows_ext[31:0];
            q_pages_reg[wr_ptr_reg] <= pages_ext[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                q_cnt_reg <= q_cnt_reg + QCNT_W'(1);
            else if (pop && !push)
                q_cnt_reg <= q_cnt_reg - QCNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // record output register
    // ------------------------------------------------------------------
    logic        out_vld_reg;
    logic [1:0]  sub_reg;       // record number within a page end
    logic        load;
    logic        head_page;
    logic [1:0]  code_sel;
    logic        phase_sel;
    logic        last_sel;
    logic        err_any;
    logic [1:0]  status_code_reg;
    logic        phase_reg;
    logic        last_reg;
    logic [7:0]  err_one_out_reg, err_two_out_reg, width_out_reg, media_out_reg;
    logic [7:0]  tape_out_reg, ink_out_reg, model_out_reg;
    logic [31:0] rows_out_reg, pages_out_reg;

    assign load      = !q_empty && (!out_vld_reg || !out_stall);
    assign head_page = q_page_reg[rd_ptr_reg];
    assign err_any   = (err_one_reg != 8'd0) || (err_two_reg != 8'd0);

    // record kind: status reply, or the three records of a page end
    always_comb
    begin
        code_sel  = lpcp_pkg::SC_REPLY;
        phase_sel = lpcp_pkg::PH_EDIT;
        last_sel  = 1'b1;
        if (head_page)
        begin
            case (sub_reg)
                2'd0:
                begin
                    code_sel  = lpcp_pkg::SC_PHASE;
                    phase_sel = lpcp_pkg::PH_PRINT;
                    last_sel  = 1'b0;
                end
                2'd1:
                begin
                    code_sel  = lpcp_pkg::SC_DONE;
                    phase_sel = lpcp_pkg::PH_PRINT;
                    last_sel  = 1'b0;
                end
                default:
                begin
                    code_sel  = lpcp_pkg::SC_PHASE;
                    phase_sel = lpcp_pkg::PH_EDIT;
                    last_sel  = 1'b1;
                end
            endcase
        end
        // any error flag forces the error status
        if (err_any)
            code_sel = lpcp_pkg::SC_ERROR;
    end

    assign pop = load && last_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            sub_reg     <= '0;
        end
        else
        begin
            if (load)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;

            if (load)
                sub_reg <= last_sel ? 2'd0 : sub_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_code_reg <= code_sel;
            phase_reg       <= phase_sel;
            last_reg        <= last_sel;
            err_one_out_reg <= err_one_reg;
            err_two_out_reg <= err_two_reg;
            width_out_reg   <= width_reg;
            media_out_reg   <= media_reg;
            tape_out_reg    <= tape_reg;
            ink_out_reg     <= ink_reg;
            model_out_reg   <= model_reg;
            rows_out_reg    <= q_rows_reg[rd_ptr_reg];
            pages_out_reg   <= q_pages_reg[rd_ptr_reg];
        end
    end

    assign out_valid   = out_vld_reg;
    assign status_code = status_code_reg;
    assign phase       = phase_reg;
    assign err_one     = err_one_out_reg;
    assign err_two     = err_two_out_reg;
    assign tape_width  = width_out_reg;
    assign media_code  = media_out_reg;
    assign tape_id     = tape_out_reg;
    assign text_id     = ink_out_reg;
    assign model_id    = model_out_reg;
    assign rows_count  = rows_out_reg;
    assign pages_count = pages_out_reg;
    assign last        = last_reg;

endmodule

FILE: sv/lpcp_checker.sv
// port-level checks of the label printer command parser and their bind
module lpcp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status_code,
    input logic        phase,
    input logic [7:0]  err_one,
    input logic [7:0]  err_two,
    input logic        last
);

    // a stalled record stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status_code) && $stable(last))
        else $error("stalled record changed");

    // a page end's records come back to back
    a_group_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |=> out_valid)
        else $error("record group broken");

    // only the closing record of an item is in the editing phase
    a_phase_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (phase == lpcp_pkg::PH_EDIT) == last)
        else $error("phase does not match record position");

    // error flags force the error status
    a_err_force: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (err_one != 8'd0 || err_two != 8'd0)
            |-> status_code == lpcp_pkg::SC_ERROR)
        else $error("error flags not reflected");

endmodule

bind label_printer_command_parser lpcp_checker u_lpcp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status_code (status_code),
    .phase       (phase),
    .err_one     (err_one),
    .err_two     (err_two),
    .last        (last)
);
